// ----- hw/rtl/switch_debounce_key_report_macros.svh -----
// Assertion macros shared by the switch debounce key report RTL.
`ifndef SWITCH_DEBOUNCE_KEY_REPORT_MACROS_SVH
`define SWITCH_DEBOUNCE_KEY_REPORT_MACROS_SVH

// Same-cycle implication, checked on clk, disabled in reset
`define SDKR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, disabled in reset
`define SDKR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sdkr_pkg.sv -----
// Package: widths, register map and opcodes for the switch debounce key report block.
package sdkr_pkg;

  localparam int SW_SLOTS         = 7;
  localparam int NUM_SWITCHES_DEF = 7;
  localparam int CODE_W           = 8;
  localparam int COUNT_W          = 8;
  localparam int RAW_W            = 7;
  localparam int ADDR_W           = 5;
  localparam int DATA_W           = 32;

  localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd4;

  // Request opcodes
  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  // Register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_DEBOUNCE = 3'd0,
    REG_KEY_0    = 3'd1,
    REG_KEY_1    = 3'd2,
    REG_KEY_2    = 3'd3,
    REG_KEY_3    = 3'd4,
    REG_KEY_4    = 3'd5,
    REG_KEY_5    = 3'd6,
    REG_KEY_6    = 3'd7
  } reg_idx_t;

endpackage

// ----- hw/rtl/sdkr_if.sv -----
// Interfaces: switch sample request channel and key report channel.
interface sdkr_req_if;
  logic                        valid;
  logic                        ready;
  sdkr_pkg::op_t               op;
  logic [sdkr_pkg::RAW_W-1:0]  raw_pressed;

  modport source (output valid, output op, output raw_pressed, input ready);
  modport sink   (input valid, input op, input raw_pressed, output ready);
endinterface

interface sdkr_rpt_if;
  logic                        valid;
  logic                        ready;
  logic                        report_sent;
  logic [sdkr_pkg::CODE_W-1:0] code_0;
  logic [sdkr_pkg::CODE_W-1:0] code_1;
  logic [sdkr_pkg::CODE_W-1:0] code_2;
  logic [sdkr_pkg::CODE_W-1:0] code_3;
  logic [sdkr_pkg::CODE_W-1:0] code_4;
  logic [sdkr_pkg::CODE_W-1:0] code_5;
  logic [sdkr_pkg::CODE_W-1:0] code_6;

  modport source (output valid, output report_sent, output code_0, output code_1,
                  output code_2, output code_3, output code_4, output code_5,
                  output code_6, input ready);
  modport sink   (input valid, input report_sent, input code_0, input code_1,
                  input code_2, input code_3, input code_4, input code_5,
                  input code_6, output ready);
endinterface

// ----- hw/rtl/switch_debounce_key_report.sv -----
// Switch debounce key report: lockout counters per switch and key-code report output.
//
// Takes one request per clock: a tick (op = tick) counts every nonzero lockout
// counter down by one and gives no report; a report request (op = report) samples
// raw_pressed, lets each unlocked switch whose level differs from the last reported
// one take the new level and reload its counter from debounce_ticks, and gives
// exactly one report in the next cycle: report_sent = 1 with the key code of each
// pressed switch if anything changed since the last report (also on the first
// report request after reset), else report_sent = 0 and all codes zero. The result sits
// in a single output register; a new request is taken whenever that register is empty
// or being drained in the same cycle, so throughput is one request per cycle as long
// as the report side keeps ready high. Registers via APB at 4*index: debounce_ticks
// (0, reset 4) and key_code_0..6 (1..7, reset 0); write them only while idle.
`include "switch_debounce_key_report_macros.svh"

module switch_debounce_key_report #(
  parameter int NUM_SWITCHES = sdkr_pkg::NUM_SWITCHES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  sdkr_req_if.sink                      req,
  sdkr_rpt_if.source                    rpt,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdkr_pkg::ADDR_W-1:0]   paddr,
  input  logic [sdkr_pkg::DATA_W-1:0]   pwdata,
  output logic [sdkr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int NS   = NUM_SWITCHES;
  localparam int KI_W = $clog2(sdkr_pkg::SW_SLOTS);

  // Configuration registers
  logic [sdkr_pkg::COUNT_W-1:0] debounce_ticks;
  logic [sdkr_pkg::CODE_W-1:0]  key_code [sdkr_pkg::SW_SLOTS];

  // Debounce state; reported level equals the debounced level after every request
  logic [sdkr_pkg::COUNT_W-1:0] lockout_count [NS];
  logic [NS-1:0]                level;
  logic [NS-1:0]                level_next;
  logic [NS-1:0]                unlocked;
  logic [NS-1:0]                changed;
  logic                         change_pending;

  // Result register
  logic                         rpt_valid;
  logic                         report_sent;
  logic [sdkr_pkg::CODE_W-1:0]  code [sdkr_pkg::SW_SLOTS];
  logic [sdkr_pkg::CODE_W-1:0]  code_next [sdkr_pkg::SW_SLOTS];

  logic                         req_fire;
  logic                         is_tick;
  logic                         is_report;
  logic                         send;
  logic                         cfg_write;
  sdkr_pkg::reg_idx_t           reg_idx;
  logic [KI_W-1:0]              key_idx;

  // Handshakes
  assign req.ready = !rpt_valid || rpt.ready;
  assign req_fire  = req.valid && req.ready;
  assign is_tick   = req_fire && (req.op == sdkr_pkg::OP_TICK);
  assign is_report = req_fire && (req.op == sdkr_pkg::OP_REPORT);

  // APB register port
  assign pready    = 1'b1;
  assign reg_idx   = sdkr_pkg::reg_idx_t'(paddr[4:2]);
  assign key_idx   = KI_W'(paddr[4:2] - 3'd1);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= sdkr_pkg::DEBOUNCE_RESET;
      for (int k = 0; k < sdkr_pkg::SW_SLOTS; k++) begin
        key_code[k] <= '0;
      end
    end else if (cfg_write) begin
      if (reg_idx == sdkr_pkg::REG_DEBOUNCE) begin
        debounce_ticks <= pwdata[sdkr_pkg::COUNT_W-1:0];
      end else begin
        key_code[key_idx] <= pwdata[sdkr_pkg::CODE_W-1:0];
      end
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      sdkr_pkg::REG_DEBOUNCE: prdata = sdkr_pkg::DATA_W'(debounce_ticks);
      default:                prdata = sdkr_pkg::DATA_W'(key_code[key_idx]);
    endcase
  end

  // Per-switch change detect and lockout counters
  for (genvar g = 0; g < NS; g++) begin : g_sw
    assign unlocked[g]   = (lockout_count[g] == '0);
    assign changed[g]    = unlocked[g] && (req.raw_pressed[g] != level[g]);
    assign level_next[g] = changed[g] ? req.raw_pressed[g] : level[g];

    always_ff @(posedge clk) begin
      if (rst) begin
        lockout_count[g] <= '0;
      end else if (is_tick && !unlocked[g]) begin
        lockout_count[g] <= lockout_count[g] - 1'b1;
      end else if (is_report && changed[g]) begin
        lockout_count[g] <= debounce_ticks;
      end
    end
  end

  assign send = change_pending || (|changed);

  // Level and change mark update on report requests
  always_ff @(posedge clk) begin
    if (rst) begin
      level          <= '0;
      change_pending <= 1'b1;
    end else if (is_report) begin
      level          <= level_next;
      change_pending <= 1'b0;
    end
  end

  // Key codes for the report; slots beyond the switch count stay zero
  for (genvar g = 0; g < sdkr_pkg::SW_SLOTS; g++) begin : g_code
    if (g < NS) begin : g_used
      assign code_next[g] = (send && level_next[g]) ? key_code[g] : '0;
    end else begin : g_unused
      assign code_next[g] = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (is_report) begin
      rpt_valid <= 1'b1;
    end else if (rpt.ready) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_report) begin
      report_sent <= send;
      for (int k = 0; k < sdkr_pkg::SW_SLOTS; k++) begin
        code[k] <= code_next[k];
      end
    end
  end

  assign rpt.valid       = rpt_valid;
  assign rpt.report_sent = report_sent;
  assign rpt.code_0      = code[0];
  assign rpt.code_1      = code[1];
  assign rpt.code_2      = code[2];
  assign rpt.code_3      = code[3];
  assign rpt.code_4      = code[4];
  assign rpt.code_5      = code[5];
  assign rpt.code_6      = code[6];

  // Checks
  `SDKR_ASSERT_NEXT(a_tick_no_result, is_tick && !rpt_valid, !rpt_valid, "tick produced a report")
  `SDKR_ASSERT_NEXT(a_report_result, is_report, rpt_valid, "report request gave no result")
  `SDKR_ASSERT_NEXT(a_pending_cleared, is_report, !change_pending, "change mark not cleared")
  `SDKR_ASSERT_NEXT(a_locked_hold, is_report, ((level ^ $past(level)) & ~$past(unlocked)) == '0, "locked switch changed level")
  `SDKR_ASSERT_NOW(a_quiet_report, rpt_valid && !report_sent, (code[0] | code[1] | code[2] | code[3] | code[4] | code[5] | code[6]) == '0, "codes set in empty report")

endmodule
